>>> sv/gba_pkg.sv
// Shared types and constants for the Gumbel bandit arm selector.
package gba_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEL_GUM,
    ST_SEL_RD,
    ST_SEL_MUL1,
    ST_SEL_MUL2,
    ST_SEL_CMP,
    ST_RW_RD,
    ST_RW_MUL,
    ST_RW_D1S,
    ST_RW_D1W,
    ST_RW_D2S,
    ST_RW_D2W,
    ST_RW_SQW
  } top_state_t;

  typedef enum logic [2:0] {
    G_IDLE,
    G_NORM,
    G_SQ,
    G_LOGD,
    G_LN2H,
    G_LN2L,
    G_FIN
  } gum_state_t;

  localparam logic REQ_SELECT = 1'b0;
  localparam logic REQ_REWARD = 1'b1;

  localparam logic CFG_NUM_ARMS = 1'b0;
  localparam logic CFG_GAIN     = 1'b1;

  localparam logic [4:0]  NUM_ARMS_RESET = 5'd16;
  localparam logic [15:0] GAIN_RESET     = 16'd1024;

  localparam logic [31:0] LN2_Q31        = 32'd1488522236;
  localparam logic signed [39:0] NEG_LN_LN2_Q28 = 40'sd98385063;
  localparam logic [33:0] LOG_TOP_Q28    = 34'h1_0000_0000;
  localparam logic [34:0] LOG_BIAS_Q28   = 35'h1_C000_0000;
  localparam logic [4:0]  SQ_STEPS       = 5'd28;
  localparam logic signed [26:0] BONUS_MAX = 27'sd16777215;
  localparam logic signed [15:0] Z_MIN   = -16'sd32768;

endpackage

>>> sv/gba_div.sv
// Serial restoring divider, one quotient bit per cycle.
module gba_div #(
  parameter int DW = 48,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  localparam int CNW = $clog2(DW + 1);

  logic           run;
  logic [CNW-1:0] cnt;
  logic [VW:0]    rem;
  logic [VW-1:0]  dv;
  logic [DW-1:0]  q;
  logic [VW:0]    rem_s;
  logic           ge;
  logic [VW:0]    rem_n;

  assign rem_s = {rem[VW-1:0], q[DW-1]};
  assign ge    = rem_s >= {1'b0, dv};
  assign rem_n = ge ? rem_s - {1'b0, dv} : rem_s;
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNW'(DW);
        rem <= '0;
        q   <= dividend;
        dv  <= divisor;
      end else if (run) begin
        rem <= rem_n;
        q   <= {q[DW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> sv/gba_sqrt.sv
// Bit-serial integer square root of a 33-bit value, one root bit per cycle.
module gba_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] radicand,
  output logic        done,
  output logic [16:0] root
);
  logic        run;
  logic [4:0]  b;
  logic [32:0] rad;
  logic [16:0] t;
  logic [33:0] tt;

  assign t    = root | (17'd1 << b);
  assign tt   = 34'(t) * 34'(t);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        b    <= 5'd16;
        rad  <= radicand;
        root <= '0;
      end else if (run) begin
        if (tt <= {1'b0, rad}) root <= t;
        b <= b - 1'b1;
        if (b == 5'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> sv/gba_gumbel.sv
// Gumbel value Z = -ln(-ln u) in Q4.12 by iterated squaring on one shared multiplier.
module gba_gumbel (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        sample,
  output logic               done,
  output logic signed [15:0] z
);
  import gba_pkg::*;

  gum_state_t st, st_next;
  logic [32:0] m;
  logic [5:0]  p;
  logic [27:0] f;
  logic [31:0] sq;
  logic [4:0]  step;
  logic        pass;
  logic [32:0] mag;
  logic        ysign;
  logic [63:0] acc;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [32:0] sq_t;
  logic [33:0] lg;
  logic [32:0] l_val;
  logic signed [34:0] y;
  logic [64:0] rnd;
  logic [33:0] prod_r;
  logic signed [39:0] s, zq, zs;

  always_comb begin
    mul_a = sq;
    mul_b = sq;
    unique case (st)
      G_LN2H: begin
        mul_a = {15'd0, mag[32:16]};
        mul_b = LN2_Q31;
      end
      G_LN2L: begin
        mul_a = {16'd0, mag[15:0]};
        mul_b = LN2_Q31;
      end
      default: ;
    endcase
  end

  assign mul_p  = 64'(mul_a) * 64'(mul_b);
  assign sq_t   = mul_p[63:31];
  assign lg     = {p, f};
  assign l_val  = 33'(LOG_TOP_Q28 - lg);
  assign y      = $signed({1'b0, lg}) - $signed(LOG_BIAS_Q28);
  assign rnd    = 65'(acc) + 65'(64'd1 << 30);
  assign prod_r = rnd[64:31];
  assign s      = ysign ? -$signed({6'd0, prod_r}) : $signed({6'd0, prod_r});
  assign zq     = NEG_LN_LN2_Q28 - s;
  assign zs     = (zq + 40'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (rst) st <= G_IDLE;
    else     st <= st_next;
  end

  always_comb begin
    st_next = st;
    unique case (st)
      G_IDLE: if (start && sample != 16'd0) st_next = G_NORM;
      G_NORM: if (m[32]) st_next = G_SQ;
      G_SQ:   if (step == SQ_STEPS - 1'b1) st_next = G_LOGD;
      G_LOGD: st_next = pass ? G_LN2H : G_NORM;
      G_LN2H: st_next = G_LN2L;
      G_LN2L: st_next = G_FIN;
      G_FIN:  st_next = G_IDLE;
      default: st_next = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        G_IDLE: if (start) begin
          if (sample == 16'd0) begin
            z    <= Z_MIN;
            done <= 1'b1;
          end
          m    <= {17'd0, sample};
          p    <= 6'd32;
          pass <= 1'b0;
        end
        G_NORM: begin
          if (m[32]) begin
            sq   <= m[32:1];
            f    <= '0;
            step <= '0;
          end else begin
            m <= {m[31:0], 1'b0};
            p <= p - 1'b1;
          end
        end
        G_SQ: begin
          step <= step + 1'b1;
          if (sq_t[32]) begin
            f  <= {f[26:0], 1'b1};
            sq <= sq_t[32:1];
          end else begin
            f  <= {f[26:0], 1'b0};
            sq <= sq_t[31:0];
          end
        end
        G_LOGD: begin
          if (!pass) begin
            // Second pass takes the log of 16 - log2(sample), still in Q.28.
            m    <= l_val;
            p    <= 6'd32;
            pass <= 1'b1;
          end else begin
            ysign <= y[34];
            mag   <= y[34] ? 33'(-y) : 33'(y);
          end
        end
        G_LN2H: acc <= mul_p << 16;
        G_LN2L: acc <= acc + mul_p;
        G_FIN: begin
          done <= 1'b1;
          if (zs > 40'sd32767)       z <= 16'sh7FFF;
          else if (zs < -40'sd32768) z <= Z_MIN;
          else                       z <= 16'(zs);
        end
        default: ;
      endcase
    end
  end
endmodule

>>> sv/gumbel_bandit_arm_selector.sv
// Top level of the Gumbel bandit arm selector: sequencer, arm store and scoring datapath.
//
// A transaction is taken at a rising edge with start high and busy low; busy stays high
// until the request is finished. Configuration is written through cfg_we, cfg_index and
// cfg_data (index 0 num_arms, index 1 explore_gain) at any edge with cfg_we high.
// A select request (req_type 0) first maps uniform_sample to a Gumbel value on the shared
// squaring multiplier: a zero sample maps straight to Z_MIN, any other goes through two
// normalising shift searches, 56 squarings and the set-up and final scaling.
// The arms are then scanned one by one, each through ST_SEL_RD, ST_SEL_MUL1, ST_SEL_MUL2
// and ST_SEL_CMP, through the single read port of the arm store.
// The winner appears on chosen_arm with done high for exactly one cycle, in the cycle in
// which busy falls; the receiver cannot stall it, so results are never held back.
// A reward request (req_type 1) gives no result. It runs the serial divider, of width
// D = max(COUNT_BITS+16, 33), twice, once for the new average and once for 2^32/count,
// followed by a 17-step square root whose result is cached per arm for the scan.
// Rewards to an index at or beyond MAX_ARMS are dropped at once.
// Reset clears the state machine, sets the registers to their defaults and marks every
// arm unpulled through one valid flop per arm, so no clearing pass is needed.
module gumbel_bandit_arm_selector #(
  parameter int MAX_ARMS   = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [3:0]  arm_index,
  input  logic [15:0] reward_value,
  input  logic [15:0] uniform_sample,
  output logic        done,
  output logic [3:0]  chosen_arm,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import gba_pkg::*;

  localparam int AW = $clog2(MAX_ARMS);
  localparam int DW = (COUNT_BITS + 16 > 33) ? COUNT_BITS + 16 : 33;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  top_state_t state, state_next;

  logic [4:0]  num_arms;
  logic [15:0] explore_gain;

  logic [15:0]           avg_mem [MAX_ARMS];
  logic [COUNT_BITS-1:0] cnt_mem [MAX_ARMS];
  logic [16:0]           rsq_mem [MAX_ARMS];
  logic [MAX_ARMS-1:0]   valid;

  logic [AW-1:0]         rd_addr;
  logic [15:0]           avg_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [16:0]           rsq_q;
  logic                  vld_q;

  logic                  accept;
  logic                  arm_ok;
  logic [31:0]           n_clamp;
  logic [AW-1:0]         arm_r;
  logic [15:0]           rv_r;
  logic [AW-1:0]         n_last;
  logic [AW-1:0]         scan_i;
  logic [AW-1:0]         best;
  logic signed [26:0]    best_score;

  logic [COUNT_BITS-1:0] c_cur, c_new, c_r;
  logic [15:0]           avg_cur;
  logic [DW-1:0]         num_r;
  logic [15:0]           avg_new;

  logic                  div_start, div_done;
  logic [DW-1:0]         div_dividend, div_q;
  logic                  sqrt_start, sqrt_done;
  logic [16:0]           sqrt_root;
  logic                  gum_start, gum_done;
  logic signed [15:0]    gum_z;

  logic signed [15:0]    z_r;
  logic [15:0]           zmag;
  logic [32:0]           cr_r;
  logic [48:0]           prod_r;
  logic [24:0]           bmag;
  logic signed [26:0]    bonus, score;
  logic                  take;

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;
  assign arm_ok = 32'(arm_index) < 32'(MAX_ARMS);

  always_comb begin
    n_clamp = (num_arms == 5'd0) ? 32'd1 : 32'(num_arms);
    if (n_clamp > 32'(MAX_ARMS)) n_clamp = 32'(MAX_ARMS);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_arms     <= NUM_ARMS_RESET;
      explore_gain <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_ARMS: num_arms     <= cfg_data[4:0];
        CFG_GAIN:     explore_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Arm store: one write port, one registered read port.
  assign rd_addr = (state == ST_RW_RD) ? arm_r : scan_i;

  always_ff @(posedge clk) begin
    avg_q <= avg_mem[rd_addr];
    cnt_q <= cnt_mem[rd_addr];
    rsq_q <= rsq_mem[rd_addr];
    if (state == ST_RW_SQW && sqrt_done) begin
      avg_mem[arm_r] <= avg_new;
      cnt_mem[arm_r] <= c_r;
      rsq_mem[arm_r] <= sqrt_root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid[rd_addr];
      if (state == ST_RW_SQW && sqrt_done) valid[arm_r] <= 1'b1;
    end
  end

  // Shared units.
  assign gum_start    = accept && req_type == REQ_SELECT;
  assign div_start    = state == ST_RW_D1S || state == ST_RW_D2S;
  assign div_dividend = (state == ST_RW_D1S) ? num_r : DW'(64'h1_0000_0000);
  assign sqrt_start   = state == ST_RW_D2W && div_done;

  gba_gumbel u_gumbel (
    .clk    (clk),
    .rst    (rst),
    .start  (gum_start),
    .sample (uniform_sample),
    .done   (gum_done),
    .z      (gum_z)
  );

  gba_div #(
    .DW (DW),
    .VW (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (c_r),
    .done     (div_done),
    .quotient (div_q)
  );

  gba_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (div_q[32:0]),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Reward arithmetic; an unpulled arm reads as zero count and zero average.
  assign c_cur   = vld_q ? cnt_q : '0;
  assign c_new   = (c_cur == COUNT_MAX) ? c_cur : c_cur + 1'b1;
  assign avg_cur = vld_q ? avg_q : 16'd0;

  // Scoring.
  assign zmag  = z_r[15] ? 16'(-z_r) : 16'(z_r);
  assign bmag  = 25'((50'(prod_r) + 50'(1 << 23)) >> 24);

  always_comb begin
    if (z_r == 16'sd0)  bonus = 27'sd0;
    else if (!vld_q)    bonus = z_r[15] ? -BONUS_MAX : BONUS_MAX;
    else if (z_r[15])   bonus = -$signed({2'b00, bmag});
    else                bonus = $signed({2'b00, bmag});
  end

  assign score = $signed({11'd0, avg_cur}) + bonus;
  assign take  = scan_i == '0 || score > best_score;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) begin
        if (req_type == REQ_SELECT) state_next = ST_SEL_GUM;
        else if (arm_ok)            state_next = ST_RW_RD;
      end
      ST_SEL_GUM:  if (gum_done) state_next = ST_SEL_RD;
      ST_SEL_RD:   state_next = ST_SEL_MUL1;
      ST_SEL_MUL1: state_next = ST_SEL_MUL2;
      ST_SEL_MUL2: state_next = ST_SEL_CMP;
      ST_SEL_CMP:  state_next = (scan_i == n_last) ? ST_IDLE : ST_SEL_RD;
      ST_RW_RD:    state_next = ST_RW_MUL;
      ST_RW_MUL:   state_next = ST_RW_D1S;
      ST_RW_D1S:   state_next = ST_RW_D1W;
      ST_RW_D1W:   if (div_done) state_next = ST_RW_D2S;
      ST_RW_D2S:   state_next = ST_RW_D2W;
      ST_RW_D2W:   if (div_done) state_next = ST_RW_SQW;
      ST_RW_SQW:   if (sqrt_done) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: if (accept) begin
          arm_r  <= AW'(arm_index);
          rv_r   <= reward_value;
          n_last <= AW'(n_clamp - 32'd1);
          scan_i <= '0;
        end
        ST_SEL_GUM:  if (gum_done) z_r <= gum_z;
        ST_SEL_MUL1: cr_r   <= 33'(explore_gain) * 33'(rsq_q);
        ST_SEL_MUL2: prod_r <= 49'(cr_r) * 49'(zmag);
        ST_SEL_CMP: begin
          if (take) begin
            best       <= scan_i;
            best_score <= score;
          end
          if (scan_i == n_last) begin
            done       <= 1'b1;
            chosen_arm <= take ? 4'(scan_i) : 4'(best);
          end else begin
            scan_i <= scan_i + 1'b1;
          end
        end
        ST_RW_MUL: begin
          c_r   <= c_new;
          num_r <= DW'(c_new - 1'b1) * DW'(avg_cur) + DW'(rv_r);
        end
        ST_RW_D1W: if (div_done) avg_new <= div_q[15:0];
        default: ;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_gum_state: assert property (@(posedge clk) disable iff (rst)
    gum_done |-> state == ST_SEL_GUM)
    else $error("Gumbel result outside select phase");

  a_sqrt_state: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == ST_RW_SQW)
    else $error("square root result outside reward phase");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEL_CMP && scan_i == n_last) |=> done)
    else $error("scan finished without a result");

endmodule

>>> sim/gumbel_bandit_arm_selector_chk.sv
// Checker for the Gumbel bandit arm selector: arm state model, arm choice prediction and compare.
module gumbel_bandit_arm_selector_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        req_type,
  input  logic [3:0]  arm_index,
  input  logic [15:0] reward_value,
  input  logic [15:0] uniform_sample,
  input  logic        done,
  input  logic [3:0]  chosen_arm,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          outstanding
);
  import gba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARMS = 16;
  localparam longint unsigned COUNT_SAT = 64'hFFFF_FFFF;
  localparam longint ONE_Q28 = 64'sd268435456;
  localparam longint unsigned LN2_Q31_C = 64'd1488522236;
  localparam longint NEG_LNLN2_Q28 = 64'sd98385063;
  localparam longint GAIN_BONUS_MAX = 64'sd16777215;

  logic [4:0]  arms_cfg;
  logic [15:0] gain_cfg;
  logic [15:0] avg_q16 [ARMS];
  logic [31:0] pulls [ARMS];
  logic [3:0]  arm_choices [$];

  assign outstanding = arm_choices.size();

  // log2 of x >= 1 in Q.28, by repeated truncating squaring of the mantissa.
  function automatic longint log2_fix(longint unsigned x);
    int p;
    longint unsigned m;
    longint unsigned f;
    p = 63;
    f = 0;
    while (p > 0 && x[p] == 1'b0) p--;
    m = (p <= 31) ? (x << (31 - p)) : (x >> (p - 31));
    for (int i = 0; i < 28; i++) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= 64'h1_0000_0000) begin
        f = f | 64'd1;
        m = m >> 1;
      end
    end
    return longint'(p) * ONE_Q28 + longint'(f);
  endfunction

  function automatic longint gumbel_z(logic [15:0] k);
    longint unsigned l, mag, prod, biased;
    longint y, s, zq, z;
    if (k == 16'd0) return -32768;
    l = (64'd16 << 28) - longint'(log2_fix(64'(k)));
    y = log2_fix(l) - 64'sd28 * ONE_Q28;
    mag = (y < 0) ? longint'(-y) : longint'(y);
    prod = (mag * LN2_Q31_C + (64'd1 << 30)) >> 31;
    s = (y < 0) ? -longint'(prod) : longint'(prod);
    zq = NEG_LNLN2_Q28 - s;
    biased = longint'(zq + (64'sd1 <<< 40));
    z = longint'((biased + 64'd32768) >> 16) - (64'sd1 <<< 24);
    if (z > 32767) z = 32767;
    if (z < -32768) z = -32768;
    return z;
  endfunction

  function automatic longint unsigned inv_sqrt_q16(logic [31:0] cnt);
    longint unsigned q, r, t;
    q = (64'd1 << 32) / 64'(cnt);
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= q) r = t;
    end
    return r;
  endfunction

  function automatic longint explore_bonus(logic [31:0] cnt, longint z);
    longint unsigned mag;
    if (z == 0) return 0;
    // An arm never pulled gets the full bonus in the direction of Z.
    if (cnt == 32'd0) return (z > 0) ? GAIN_BONUS_MAX : -GAIN_BONUS_MAX;
    mag = 64'(gain_cfg) * inv_sqrt_q16(cnt);
    mag = mag * longint'((z < 0) ? -z : z);
    mag = (mag + (64'd1 << 23)) >> 24;
    return (z < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [3:0] pick_arm(logic [15:0] u);
    int n;
    int best;
    longint z, sc, best_sc;
    n = int'(arms_cfg);
    best = 0;
    best_sc = 0;
    if (n == 0) n = 1;
    if (n > ARMS) n = ARMS;
    z = gumbel_z(u);
    for (int i = 0; i < n; i++) begin
      sc = longint'(avg_q16[i]) + explore_bonus(pulls[i], z);
      if (i == 0 || sc > best_sc) begin
        best_sc = sc;
        best = i;
      end
    end
    return best[3:0];
  endfunction

  always @(posedge clk) begin
    longint unsigned c, num;
    if (rst) begin
      arms_cfg <= NUM_ARMS_RESET;
      gain_cfg <= GAIN_RESET;
      for (int i = 0; i < ARMS; i++) begin
        avg_q16[i] <= '0;
        pulls[i] <= '0;
      end
      arm_choices.delete();
      errors <= 0;
    end else begin
      if (done) begin
        if (arm_choices.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual chosen_arm %0d",
                   $time, chosen_arm);
          errors <= errors + 1;
        end else if (arm_choices[0] !== chosen_arm) begin
          $display("%0t: chosen_arm mismatch, expected %0d, actual %0d",
                   $time, arm_choices[0], chosen_arm);
          errors <= errors + 1;
          void'(arm_choices.pop_front());
        end else begin
          void'(arm_choices.pop_front());
        end
      end
      if (start && !busy) begin
        if (req_type == REQ_SELECT) begin
          arm_choices.push_back(pick_arm(uniform_sample));
        end else begin
          c = 64'(pulls[arm_index]);
          if (c < COUNT_SAT) c = c + 1;
          num = (c - 1) * 64'(avg_q16[arm_index]) + 64'(reward_value);
          pulls[arm_index] <= c[31:0];
          avg_q16[arm_index] <= 16'(num / c);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_ARMS) arms_cfg <= cfg_data[4:0];
        else gain_cfg <= cfg_data;
      end
    end
  end

endmodule

>>> sim/gumbel_bandit_arm_selector_tb.sv
// Testbench top for the Gumbel bandit arm selector: clock, reset, stimulus and verdict.
module gumbel_bandit_arm_selector_tb;
  import gba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [15:0] U_NEAR_ZERO_Z = 16'd24109;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type = REQ_SELECT;
  logic [3:0]  arm_index = '0;
  logic [15:0] reward_value = '0;
  logic [15:0] uniform_sample = '0;
  logic        done;
  logic [3:0]  chosen_arm;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_NUM_ARMS;
  logic [15:0] cfg_data = '0;
  int          errors;
  int          outstanding;
  int          cycles = 0;
  bit          calm;

  always #5 clk = ~clk;

  gumbel_bandit_arm_selector dut (.*);

  gumbel_bandit_arm_selector_chk chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Holds start high until the transaction is taken; start is left high afterwards.
  task automatic issue(logic kind, logic [3:0] arm, logic [15:0] rew, logic [15:0] u);
    start <= 1'b1;
    req_type <= kind;
    arm_index <= arm;
    reward_value <= rew;
    uniform_sample <= u;
    do @(posedge clk); while (busy);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // A reward gives no result and may still be running.
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    logic [15:0] u, rew;
    u = 16'($urandom);
    rew = 16'($urandom);
    case ($urandom_range(0, 9))
      0: u = 16'd0;
      1: u = 16'hFFFF;
      2: u = U_NEAR_ZERO_Z - 16'd6 + 16'($urandom_range(0, 12));
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: rew = 16'd0;
      1: rew = 16'hFFFF;
      default: ;
    endcase
    if ($urandom_range(0, 1) == 0) issue(REQ_SELECT, 4'($urandom), 16'($urandom), u);
    else issue(REQ_REWARD, 4'($urandom_range(0, 15)), rew, 16'($urandom));
    maybe_gap();
  endtask

  initial begin
    logic [4:0]  arm_set [6];
    logic [15:0] gain_set [6];
    calm = 1'b0;
    arm_set = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16};
    gain_set = '{16'd1024, 16'd0, 16'hFFFF, 16'd4096, 16'd300, 16'd1024};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all arms unpulled, then extremes of rewards and samples.
    issue(REQ_SELECT, 4'd0, 16'd0, 16'hFFFF);
    issue(REQ_SELECT, 4'd0, 16'd0, 16'd0);
    issue(REQ_SELECT, 4'd0, 16'd0, U_NEAR_ZERO_Z);
    issue(REQ_REWARD, 4'd15, 16'hFFFF, 16'd0);
    issue(REQ_REWARD, 4'd3, 16'd0, 16'd0);
    issue(REQ_REWARD, 4'd3, 16'hFFFF, 16'd0);
    issue(REQ_SELECT, 4'd0, 16'd0, 16'd1);
    issue(REQ_SELECT, 4'd0, 16'd0, 16'h8000);
    for (int k = -3; k <= 3; k++) issue(REQ_SELECT, 4'd0, 16'd0, U_NEAR_ZERO_Z + 16'(k));
    drain();
    write_reg(CFG_NUM_ARMS, 16'd4);
    // A reward to an arm beyond the scanned range still updates it.
    issue(REQ_REWARD, 4'd9, 16'hFFFF, 16'd0);
    issue(REQ_SELECT, 4'd0, 16'd0, 16'hFFFF);
    issue(REQ_SELECT, 4'd0, 16'd0, 16'd0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_NUM_ARMS, {11'd0, arm_set[ph]});
      write_reg(CFG_GAIN, (ph == 5) ? 16'($urandom) : gain_set[ph]);
      calm = (ph == 2);
      for (int i = 0; i < 122; i++) begin
        random_item();
        if (ph == 4 && i == 60) begin
          start <= 1'b0;
          @(posedge clk);
          while (outstanding != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/gba_pkg.sv
sv/gba_div.sv
sv/gba_sqrt.sv
sv/gba_gumbel.sv
sv/gumbel_bandit_arm_selector.sv
sim/gumbel_bandit_arm_selector_chk.sv
sim/gumbel_bandit_arm_selector_tb.sv
